### rtl/core/tmot_pkg.sv
package tmot_pkg;

   // Block dimensions
   localparam int MAX_SAMPLES = 16;
   localparam int ADC_BITS    = 10;

   // Field and register widths fixed by the interface
   localparam int FIELD_W   = 10;
   localparam int COUNT_W   = 5;
   localparam int THRESH_W  = 10;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Derived widths
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = $clog2(MAX_SAMPLES * ((1 << ADC_BITS) - 1) + 1);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int CMP_W  = (ADC_BITS > THRESH_W) ? ADC_BITS : THRESH_W;

   // Register map, selected by address bit 2
   localparam logic REG_SAMPLE_COUNT   = 1'b0;
   localparam logic REG_TRIP_THRESHOLD = 1'b1;

   localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RESET   = COUNT_W'(16);
   localparam logic [THRESH_W-1:0] TRIP_THRESHOLD_RESET = THRESH_W'(1000);

   // Per-word control from the window sequencer to both lanes
   typedef struct packed {
      logic             accept;
      logic             first;
      logic             close;
      logic [CNT_W-1:0] taken;
   } lane_ctrl_type;

   // Lane status toward the merge stage
   typedef struct packed {
      logic                done;
      logic [ADC_BITS-1:0] mean;
   } lane_stat_type;

endpackage

### rtl/core/tmot_lane.sv
module tmot_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  tmot_pkg::lane_ctrl_type        ctrl,
   input  logic [tmot_pkg::ADC_BITS-1:0]  sample,
   input  logic                           ack,
   output tmot_pkg::lane_stat_type        stat
);
   import tmot_pkg::*;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ADC_BITS-1:0] min_ff, min_in;
   logic [ADC_BITS-1:0] max_ff, max_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;
   logic                load_ff, load_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    div_ff, div_in;

   logic [SUM_W-1:0]    trim_max;
   logic [SUM_W-1:0]    trim_min;
   logic [CNT_W:0]      trial;

   always_comb begin
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      taken_in = taken_ff;
      load_in  = load_ff;
      run_in   = run_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;

      // drop the extremes only where the window holds enough samples
      trim_max = (taken_ff > CNT_W'(2)) ? SUM_W'(max_ff) : '0;
      trim_min = (taken_ff > CNT_W'(1)) ? SUM_W'(min_ff) : '0;
      trial    = {rem_ff, num_ff[SUM_W-1]};

      // accumulate the sample into sum, minimum and maximum
      if (ctrl.accept) begin
         if (ctrl.first) begin
            sum_in = SUM_W'(sample);
            min_in = sample;
            max_in = sample;
         end else begin
            sum_in = sum_ff + SUM_W'(sample);
            if (sample < min_ff) min_in = sample;
            if (sample > max_ff) max_in = sample;
         end
         if (ctrl.close) begin
            load_in  = 1'b1;
            taken_in = ctrl.taken;
         end
      end

      // load the divider with the trimmed sum and sample count
      if (load_ff) begin
         load_in = 1'b0;
         run_in  = 1'b1;
         num_in  = sum_ff - trim_max - trim_min;
         rem_in  = '0;
         div_in  = (taken_ff > CNT_W'(2)) ? taken_ff - CNT_W'(2) : CNT_W'(1);
         step_in = STEP_W'(SUM_W);
      end

      // restoring division, one quotient bit per cycle
      if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
            num_in = {num_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(trial);
            num_in = {num_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end

      // release the quotient once the merge stage has taken it
      if (ack) done_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         load_ff <= load_in;
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      taken_ff <= taken_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign stat.done = done_ff;
   assign stat.mean = num_ff[ADC_BITS-1:0];

endmodule

### rtl/core/tmot_merge.sv
module tmot_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  tmot_pkg::lane_stat_type             right_stat,
   input  tmot_pkg::lane_stat_type             left_stat,
   input  logic [tmot_pkg::THRESH_W-1:0]       trip_threshold,
   output logic                                ack,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tmot_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import tmot_pkg::*;

   logic                valid_ff, valid_in;
   logic [FIELD_W-1:0]  right_ff, right_in;
   logic [FIELD_W-1:0]  left_ff, left_in;
   logic                over_ff, over_in;

   // take both lane results when the output register is free
   always_comb begin
      ack      = right_stat.done && left_stat.done && (!valid_ff || rsp_tready);
      valid_in = valid_ff;
      right_in = right_ff;
      left_in  = left_ff;
      over_in  = over_ff;
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      if (ack) begin
         valid_in = 1'b1;
         right_in = FIELD_W'(right_stat.mean);
         left_in  = FIELD_W'(left_stat.mean);
         over_in  = (CMP_W'(right_stat.mean) > CMP_W'(trip_threshold)) ||
                    (CMP_W'(left_stat.mean) > CMP_W'(trip_threshold));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      right_ff <= right_in;
      left_ff  <= left_in;
      over_ff  <= over_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({over_ff, left_ff, right_ff});

endmodule

### rtl/core/trimmed_mean_overcurrent_trip.sv
// Trimmed-mean overcurrent trip. Each input word carries one right and one
// left half-bridge current sample. Two lanes keep a running sum, minimum and
// maximum per channel over a window of sample_count words (0 acts as 1,
// values above 16 act as 16); the word that closes the window yields one
// result word holding each channel's mean with the largest and smallest
// samples dropped (two samples: the larger one; one sample: that sample) and
// a trip flag set when either mean is above trip_threshold. A word that does
// not close a window is taken without a stall. A closing word keeps the input
// stalled while the divider is loaded, while the per-lane restoring divider
// runs (one quotient bit per cycle over the 14-bit sum) and while both
// quotients move into the output register. The stall runs longer while the
// output register still holds a result word that has not been taken.
// A waiting result does not stall words that do not close the next window.
module trimmed_mean_overcurrent_trip (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [9:0] right_sample, [19:10] left_sample, [23:20] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tmot_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: [9:0] right_current, [19:10] left_current,
   //            [20] over_current, [23:21] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tmot_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tmot_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tmot_pkg::CSR_W-1:0]          csr_pwdata,
   output logic [tmot_pkg::CSR_W-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import tmot_pkg::*;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic                busy_ff, busy_in;

   logic                csr_write;
   logic                accept;
   logic [CNT_W-1:0]    eff_count;
   logic [CNT_W-1:0]    taken;
   logic                close;
   logic                ack;
   lane_ctrl_type       ctrl;
   lane_stat_type       right_stat;
   lane_stat_type       left_stat;

   // register writes and reads
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      count_in  = count_ff;
      thresh_in = thresh_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_SAMPLE_COUNT) begin
            count_in = csr_pwdata[COUNT_W-1:0];
         end else begin
            thresh_in = csr_pwdata[THRESH_W-1:0];
         end
      end
      if (csr_paddr[2] == REG_SAMPLE_COUNT) begin
         csr_prdata = CSR_W'(count_ff);
      end else begin
         csr_prdata = CSR_W'(thresh_ff);
      end
   end

   // clamp the window length to 1..MAX_SAMPLES
   always_comb begin
      if (count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(count_ff) > MAX_SAMPLES) begin
         eff_count = CNT_W'(MAX_SAMPLES);
      end else begin
         eff_count = CNT_W'(count_ff);
      end
   end

   // window sequencer: count words, close the window, hold off during division
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign taken      = pos_ff + CNT_W'(1);
   assign close      = (taken >= eff_count);

   always_comb begin
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (accept) begin
         pos_in = close ? '0 : taken;
         if (close) busy_in = 1'b1;
      end
      if (ack) busy_in = 1'b0;
   end

   assign ctrl.accept = accept;
   assign ctrl.first  = (pos_ff == '0);
   assign ctrl.close  = close;
   assign ctrl.taken  = taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= SAMPLE_COUNT_RESET;
         thresh_ff <= TRIP_THRESHOLD_RESET;
         pos_ff    <= '0;
         busy_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         thresh_ff <= thresh_in;
         pos_ff    <= pos_in;
         busy_ff   <= busy_in;
      end
   end

   tmot_lane u_right_lane (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (ADC_BITS'(req_tdata[FIELD_W-1:0])),
      .ack    (ack),
      .stat   (right_stat)
   );

   tmot_lane u_left_lane (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (ADC_BITS'(req_tdata[2*FIELD_W-1:FIELD_W])),
      .ack    (ack),
      .stat   (left_stat)
   );

   tmot_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .right_stat     (right_stat),
      .left_stat      (left_stat),
      .trip_threshold (thresh_ff),
      .ack            (ack),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

### rtl/core/tmot_checker.sv
module tmot_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tmot_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                csr_pready
);

   // come out of reset empty and ready for a word
   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   // a new result only follows a division, during which input is held off
   a_result_after_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a closed window");

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

   // register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind trimmed_mean_overcurrent_trip tmot_checker u_tmot_checker (.*);
